/* rtl/core/mat4_vec4_transform_assert.svh */
// ----------------------------------------------------------------------------
// mat4_vec4_transform_assert.svh
// assertion macros shared by the transform block
// ----------------------------------------------------------------------------
`ifndef MAT4_VEC4_TRANSFORM_ASSERT_SVH
`define MAT4_VEC4_TRANSFORM_ASSERT_SVH

// property that must hold in the same cycle
`define M4V4_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication whose consequent is checked in the next cycle
`define M4V4_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/m4v4_pkg.sv */
// ----------------------------------------------------------------------------
// m4v4_pkg
// types and constants of the 4x4 matrix by vector transform
// ----------------------------------------------------------------------------
package m4v4_pkg;

  // lane and element geometry
  localparam int NumLanes  = 4;
  localparam int CoefW     = 16;
  localparam int VecW      = 32;
  localparam int ProdW     = CoefW + VecW;
  localparam int AccW      = ProdW + 2;
  localparam int FracShift = 12;
  localparam int ResW      = 32;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = NumLanes * CoefW;

  typedef logic signed [CoefW-1:0] coef_t;
  typedef logic signed [VecW-1:0]  vec_t;
  typedef logic signed [ProdW-1:0] prod_t;
  typedef logic signed [AccW-1:0]  acc_t;
  typedef logic signed [ResW-1:0]  res_t;
  typedef logic [CfgDataW-1:0]     column_t;

  // saturation limits
  localparam res_t ResMax = {1'b0, {(ResW-1){1'b1}}};
  localparam res_t ResMin = {1'b1, {(ResW-1){1'b0}}};

  // one lane result toward the merging stage
  typedef struct packed {
    res_t value;
    logic sat;
  } lane_res_t;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_COLUMN_0 = 3'd0,
    REG_COLUMN_1 = 3'd1,
    REG_COLUMN_2 = 3'd2,
    REG_COLUMN_3 = 3'd3
  } cfg_idx_e;

  // identity matrix after reset
  localparam column_t ColumnReset [NumLanes] = '{
    64'h0000_0000_0000_1000,
    64'h0000_0000_1000_0000,
    64'h0000_1000_0000_0000,
    64'h1000_0000_0000_0000
  };

endpackage

/* rtl/core/m4v4_lane.sv */
// ----------------------------------------------------------------------------
// m4v4_lane
// one result row: four registered products, then sum, floor shift, saturate
// ----------------------------------------------------------------------------
module m4v4_lane (
  input  logic                clk_i,
  input  logic                load_i,
  input  m4v4_pkg::coef_t     coef_i [m4v4_pkg::NumLanes],
  input  m4v4_pkg::vec_t      vec_i  [m4v4_pkg::NumLanes],
  output m4v4_pkg::lane_res_t res_o
);
  import m4v4_pkg::*;

  prod_t prod_q [NumLanes];
  acc_t  acc;
  logic  hi_ones;
  logic  hi_zeros;

  // product registers
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      for (int c = 0; c < NumLanes; c++) begin
        prod_q[c] <= prod_t'(coef_i[c]) * prod_t'(vec_i[c]);
      end
    end
  end

  // exact sum of the four products
  always_comb begin
    acc = '0;
    for (int c = 0; c < NumLanes; c++) begin
      acc = acc + acc_t'(prod_q[c]);
    end
  end

  // arithmetic shift drops the fraction bits, the bits above must be a sign run
  assign hi_ones  = &acc[AccW-1:FracShift+ResW-1];
  assign hi_zeros = ~|acc[AccW-1:FracShift+ResW-1];

  always_comb begin
    res_o.sat = !(hi_ones || hi_zeros);
    if (res_o.sat) begin
      res_o.value = acc[AccW-1] ? ResMin : ResMax;
    end else begin
      res_o.value = acc[FracShift+ResW-1:FracShift];
    end
  end

endmodule

/* rtl/core/m4v4_merge.sv */
// ----------------------------------------------------------------------------
// m4v4_merge
// output register: collects the lane results and combines their clamp flags
// ----------------------------------------------------------------------------
module m4v4_merge (
  input  logic                clk_i,
  input  logic                load_i,
  input  m4v4_pkg::lane_res_t lane_i [m4v4_pkg::NumLanes],
  output m4v4_pkg::res_t      value_o [m4v4_pkg::NumLanes],
  output logic                sat_o
);
  import m4v4_pkg::*;

  res_t value_q [NumLanes];
  logic sat_q;
  logic sat_any;

  // any lane clamped
  always_comb begin
    sat_any = 1'b0;
    for (int r = 0; r < NumLanes; r++) begin
      sat_any = sat_any | lane_i[r].sat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      for (int r = 0; r < NumLanes; r++) begin
        value_q[r] <= lane_i[r].value;
      end
      sat_q <= sat_any;
    end
  end

  assign value_o = value_q;
  assign sat_o   = sat_q;

endmodule

/* rtl/core/mat4_vec4_transform.sv */
// ----------------------------------------------------------------------------
// mat4_vec4_transform: 4x4 fixed-point matrix by vector transform
// path: an accepted input transaction passes the product registers, then the output register
// throughput: one vector per cycle unless the receiver stalls, set by the product and output registers
// reset: column registers return to the identity matrix, both stages empty
// ----------------------------------------------------------------------------
module mat4_vec4_transform (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [m4v4_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [m4v4_pkg::CfgDataW-1:0] cfg_data_i,
  // input vectors
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [31:0]            in_x_i,
  input  logic signed [31:0]            in_y_i,
  input  logic signed [31:0]            in_z_i,
  input  logic signed [31:0]            in_w_i,
  // results
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [31:0]            out_x_o,
  output logic signed [31:0]            out_y_o,
  output logic signed [31:0]            out_z_o,
  output logic signed [31:0]            out_w_o,
  output logic                          saturated_o
);
  import m4v4_pkg::*;

  column_t   col_q [NumLanes];
  column_t   col_d [NumLanes];
  vec_t      vec [NumLanes];
  coef_t     coef [NumLanes][NumLanes];
  lane_res_t lane_res [NumLanes];
  res_t      res_val [NumLanes];
  logic      s1_valid_q, s1_valid_d;
  logic      out_valid_q, out_valid_d;
  logic      s1_en;
  logic      s2_en;

  // matrix column registers
  assign cfg_ready_o = 1'b1;

  always_comb begin
    col_d = col_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        REG_COLUMN_0: col_d[0] = cfg_data_i;
        REG_COLUMN_1: col_d[1] = cfg_data_i;
        REG_COLUMN_2: col_d[2] = cfg_data_i;
        REG_COLUMN_3: col_d[3] = cfg_data_i;
        default:      col_d = col_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= ColumnReset;
    end else begin
      col_q <= col_d;
    end
  end

  // pipeline control: each stage loads when it is empty or draining
  assign s2_en      = !out_valid_q || out_ready_i;
  assign s1_en      = !s1_valid_q || s2_en;
  assign in_ready_o = s1_en;

  always_comb begin
    s1_valid_d  = s1_en ? in_valid_i : s1_valid_q;
    out_valid_d = s2_en ? s1_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // operand routing: lane r takes row r of every column
  assign vec[0] = in_x_i;
  assign vec[1] = in_y_i;
  assign vec[2] = in_z_i;
  assign vec[3] = in_w_i;

  for (genvar r = 0; r < NumLanes; r++) begin : g_lane
    for (genvar c = 0; c < NumLanes; c++) begin : g_coef
      assign coef[r][c] = col_q[c][r*CoefW +: CoefW];
    end

    m4v4_lane u_lane (
      .clk_i  (clk_i),
      .load_i (s1_en && in_valid_i),
      .coef_i (coef[r]),
      .vec_i  (vec),
      .res_o  (lane_res[r])
    );
  end

  // merging stage and output register
  m4v4_merge u_merge (
    .clk_i   (clk_i),
    .load_i  (s2_en && s1_valid_q),
    .lane_i  (lane_res),
    .value_o (res_val),
    .sat_o   (saturated_o)
  );

  assign out_valid_o = out_valid_q;
  assign out_x_o     = res_val[0];
  assign out_y_o     = res_val[1];
  assign out_z_o     = res_val[2];
  assign out_w_o     = res_val[3];

  // checks
  `include "mat4_vec4_transform_assert.svh"

  `M4V4_ASSERT(a_stall_only_when_full,
    !in_ready_o |-> (s1_valid_q && out_valid_q && !out_ready_i),
    "input stalled while pipeline has room")
  `M4V4_ASSERT_NEXT(a_accept_fills_s1, in_valid_i && in_ready_o, s1_valid_q,
    "accepted transaction lost in first stage")
  `M4V4_ASSERT_NEXT(a_s1_moves_to_out, s1_valid_q && s2_en, out_valid_q,
    "first stage result not moved to output")
  `M4V4_ASSERT(a_sat_means_clamped,
    (out_valid_o && saturated_o) |->
      (out_x_o == ResMax || out_x_o == ResMin || out_y_o == ResMax || out_y_o == ResMin ||
       out_z_o == ResMax || out_z_o == ResMin || out_w_o == ResMax || out_w_o == ResMin),
    "saturation flag without clamped component")

endmodule

/* sim/mat4_vec4_transform_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mat4_vec4_transform_test
// self-checking bench for the 4x4 fixed-point matrix by vector transform:
// loads matrices through the column write port, streams vectors with random
// idle and stall bursts on both channels, and checks every result against a
// local Q4.12 x Q16.16 multiply-accumulate with floor shift and saturation
// ----------------------------------------------------------------------------
module mat4_vec4_transform_test;
  import m4v4_pkg::*;

  // feed entries: a vector, a column write, or a drain pause
  typedef enum logic [1:0] {
    FEED_VEC,
    FEED_COL,
    FEED_DRAIN
  } feed_kind_e;

  typedef struct {
    feed_kind_e            kind;
    vec_t                  x, y, z, w;
    logic [CfgIdxW-1:0]    idx;
    column_t               data;
    int unsigned           idle_pct;
  } feed_t;

  typedef struct packed {
    res_t x, y, z, w;
    logic sat;
  } xform_res_t;

  localparam vec_t  VecMax    = 32'sh7fff_ffff;
  localparam vec_t  VecMin    = 32'sh8000_0000;
  localparam vec_t  VecOne    = 32'sh0001_0000;
  localparam coef_t CoefMax   = 16'sh7fff;
  localparam coef_t CoefMin   = 16'sh8000;
  localparam coef_t CoefOne   = 16'sh1000;
  localparam coef_t CoefLsb   = 16'sh0001;
  localparam int    NumPhases = 12;
  localparam int    PhaseVecs = 90;
  localparam int    MaxPrints = 20;

  logic clk;
  logic rst_n = 1'b0;

  // block inputs, all known from time zero
  logic               cfg_valid = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  column_t            cfg_data  = '0;
  logic               in_valid  = 1'b0;
  vec_t               in_x = '0, in_y = '0, in_z = '0, in_w = '0;
  logic               out_ready = 1'b0;

  // block outputs
  logic cfg_ready, in_ready, out_valid, out_sat;
  res_t out_x, out_y, out_z, out_w;

  // bench state
  feed_t       feed_q[$];
  xform_res_t  transformed_q[$];
  column_t     matrix_cols [NumLanes] = ColumnReset;
  int unsigned vecs_total   = 0;
  int unsigned vecs_sent    = 0;
  int unsigned results_done = 0;
  int unsigned calm_after   = 32'hffff_ffff;
  int unsigned errors       = 0;
  int unsigned prints       = 0;
  int unsigned col_writes   = 0;
  int unsigned unused_writes = 0;
  int unsigned drain_pauses = 0;
  int unsigned clamped_seen = 0;
  int unsigned settings     = 0;
  int unsigned gap_left     = 0;
  int unsigned stall_left   = 0;

  mat4_vec4_transform dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_x_i      (in_x),
    .in_y_i      (in_y),
    .in_z_i      (in_z),
    .in_w_i      (in_w),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_x_o     (out_x),
    .out_y_o     (out_y),
    .out_z_o     (out_z),
    .out_w_o     (out_w),
    .saturated_o (out_sat)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // matrix times vector with the current columns, floor shift and clamp
  function automatic xform_res_t transform_vec(vec_t vx, vec_t vy, vec_t vz, vec_t vw);
    vec_t       lane_in  [NumLanes];
    res_t       lane_out [NumLanes];
    acc_t       sum;
    acc_t       scaled;
    coef_t      k;
    xform_res_t r;
    lane_in = '{vx, vy, vz, vw};
    r.sat   = 1'b0;
    for (int row = 0; row < NumLanes; row++) begin
      sum = '0;
      for (int col = 0; col < NumLanes; col++) begin
        k   = coef_t'(matrix_cols[col][row*CoefW +: CoefW]);
        sum = sum + acc_t'(k) * acc_t'(lane_in[col]);
      end
      scaled = sum >>> FracShift;
      if (scaled > acc_t'(ResMax)) begin
        lane_out[row] = ResMax;
        r.sat = 1'b1;
      end else if (scaled < acc_t'(ResMin)) begin
        lane_out[row] = ResMin;
        r.sat = 1'b1;
      end else begin
        lane_out[row] = res_t'(scaled);
      end
    end
    r.x = lane_out[0];
    r.y = lane_out[1];
    r.z = lane_out[2];
    r.w = lane_out[3];
    return r;
  endfunction

  function automatic column_t pack_col(coef_t ex, coef_t ey, coef_t ez, coef_t ew);
    return {ew, ez, ey, ex};
  endfunction

  function automatic coef_t rand_coef();
    coef_t k;
    case ($urandom_range(9, 0))
      0: k = CoefMax;
      1: k = CoefMin;
      2: k = CoefOne;
      3: k = '0;
      4, 5: begin
        k = coef_t'($urandom_range(512, 0));
        k = k - 16'sd256;
      end
      default: k = coef_t'($urandom);
    endcase
    return k;
  endfunction

  function automatic column_t rand_col();
    return pack_col(rand_coef(), rand_coef(), rand_coef(), rand_coef());
  endfunction

  function automatic vec_t rand_comp();
    vec_t v;
    case ($urandom_range(9, 0))
      0: v = VecMax;
      1: v = VecMin;
      2: v = '0;
      3, 4, 5: begin
        v = vec_t'($urandom_range(32'h0020_0000, 0));
        v = v - 32'sh0010_0000;
      end
      default: v = vec_t'($urandom);
    endcase
    return v;
  endfunction

  task automatic add_vec(vec_t vx, vec_t vy, vec_t vz, vec_t vw, int unsigned pct);
    feed_t f;
    f          = '{kind: FEED_VEC, default: '0};
    f.x        = vx;
    f.y        = vy;
    f.z        = vz;
    f.w        = vw;
    f.idle_pct = pct;
    feed_q.push_back(f);
    vecs_total++;
  endtask

  task automatic add_col(logic [CfgIdxW-1:0] idx, column_t data);
    feed_t f;
    f      = '{kind: FEED_COL, default: '0};
    f.idx  = idx;
    f.data = data;
    feed_q.push_back(f);
  endtask

  task automatic add_drain();
    feed_t f;
    f      = '{kind: FEED_DRAIN, default: '0};
    feed_q.push_back(f);
  endtask

  // write all four columns, starting at a rotated position
  task automatic add_matrix(column_t c0, column_t c1, column_t c2, column_t c3, int rot);
    column_t cols [NumLanes];
    int      c;
    cols = '{c0, c1, c2, c3};
    for (int j = 0; j < NumLanes; j++) begin
      c = (j + rot) % NumLanes;
      add_col(cfg_idx_e'(c), cols[c]);
    end
    settings++;
  endtask

  task automatic add_flat_matrix(coef_t k);
    add_matrix(pack_col(k, k, k, k), pack_col(k, k, k, k),
               pack_col(k, k, k, k), pack_col(k, k, k, k), 0);
  endtask

  task automatic check_word(string tag, logic signed [31:0] want, logic signed [31:0] got);
    if (want !== got) begin
      errors++;
      if (prints < MaxPrints) begin
        prints++;
        $display("%0t %s mismatch: expected %0d (0x%08h), actual %0d (0x%08h)",
                 $time, tag, want, want, got, got);
      end
    end
  endtask

  // driver: vectors and column writes from the feed queue
  always @(posedge clk) begin : drive_proc
    feed_t head;
    logic  in_hold;
    logic  cfg_hold;
    logic  drained;
    if (rst_n) begin
      in_hold  = in_valid;
      cfg_hold = cfg_valid;
      // transactions completed at this edge
      if (in_valid && in_ready) begin
        transformed_q.push_back(transform_vec(in_x, in_y, in_z, in_w));
        vecs_sent++;
        in_hold = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index < NumLanes) begin
          matrix_cols[cfg_index[1:0]] = cfg_data;
        end else begin
          unused_writes++;
        end
        col_writes++;
        cfg_hold = 1'b0;
      end
      // choose what to present next
      drained = (vecs_sent == results_done);
      if (!in_hold && !cfg_hold && feed_q.size() != 0) begin
        head = feed_q[0];
        if (head.kind == FEED_VEC) begin
          if (gap_left != 0) begin
            gap_left--;
          end else if (head.idle_pct != 0 && $urandom_range(99, 0) < head.idle_pct) begin
            gap_left = $urandom_range(11, 0);
          end else begin
            in_x    <= head.x;
            in_y    <= head.y;
            in_z    <= head.z;
            in_w    <= head.w;
            in_hold = 1'b1;
            void'(feed_q.pop_front());
          end
        end else if (drained) begin
          if (head.kind == FEED_COL) begin
            cfg_index <= head.idx;
            cfg_data  <= head.data;
            cfg_hold  = 1'b1;
          end else begin
            drain_pauses++;
          end
          void'(feed_q.pop_front());
        end
      end
      in_valid  <= in_hold;
      cfg_valid <= cfg_hold;
    end
  end

  // monitor: result checks and receiver stalls
  always @(posedge clk) begin : check_proc
    xform_res_t want;
    logic       ready_next;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (transformed_q.size() == 0) begin
          errors++;
          if (prints < MaxPrints) begin
            prints++;
            $display("%0t unexpected result: expected none, actual %0d %0d %0d %0d sat %0b",
                     $time, out_x, out_y, out_z, out_w, out_sat);
          end
        end else begin
          want = transformed_q.pop_front();
          check_word("out_x", want.x, out_x);
          check_word("out_y", want.y, out_y);
          check_word("out_z", want.z, out_z);
          check_word("out_w", want.w, out_w);
          check_word("saturated", {31'd0, want.sat}, {31'd0, out_sat});
          if (want.sat) clamped_seen++;
          results_done <= results_done + 1;
        end
      end
      // stall bursts, with quiet windows and none near the end
      ready_next = 1'b1;
      if (stall_left != 0) begin
        stall_left--;
        ready_next = 1'b0;
      end else if (results_done < calm_after && (results_done / 128) % 4 != 3 &&
                   $urandom_range(99, 0) < 15) begin
        stall_left = $urandom_range(11, 0);
        ready_next = 1'b0;
      end
      out_ready <= ready_next;
    end
  end

  // stimulus and end of run
  initial begin : stim_proc
    int unsigned pct;
    // identity after reset: vectors pass through unchanged
    add_vec('0, '0, '0, '0, 0);
    add_vec(VecMax, VecMax, VecMax, VecMax, 0);
    add_vec(VecMin, VecMin, VecMin, VecMin, 0);
    add_vec(VecMax, VecMin, '0, -32'sd1, 0);
    add_vec(VecOne, -VecOne, 32'sh7fff_0000, 32'sh8000_0001, 0);
    add_drain();
    // all entries at the positive limit: both saturation directions
    add_flat_matrix(CoefMax);
    add_vec(VecMax, VecMax, VecMax, VecMax, 0);
    add_vec(VecMin, VecMin, VecMin, VecMin, 0);
    add_vec(VecMax, VecMin, VecMax, VecMin, 0);
    add_vec(32'sd1, 32'sd1, 32'sd1, 32'sd1, 0);
    // all entries at the negative limit
    add_flat_matrix(CoefMin);
    add_vec(VecMax, VecMax, VecMax, VecMax, 0);
    add_vec(VecMin, VecMin, VecMin, VecMin, 0);
    add_vec(-32'sd1, -32'sd1, -32'sd1, -32'sd1, 0);
    // smallest entries: shift rounds toward minus infinity
    add_flat_matrix(CoefLsb);
    add_vec(-32'sd1, '0, '0, '0, 0);
    add_vec(32'sd1, '0, '0, '0, 0);
    add_vec(-32'sd4097, '0, '0, '0, 0);
    // mixed columns, then writes to unused indexes must not disturb them
    add_matrix(pack_col(CoefOne, CoefMin, CoefMax, '0),
               pack_col(CoefMax, CoefOne, '0, CoefMin),
               pack_col('0, CoefMax, CoefMin, CoefOne),
               pack_col(CoefMin, '0, CoefOne, CoefMax), 1);
    for (int i = NumLanes; i < 2**CfgIdxW; i++) begin
      add_col(i[CfgIdxW-1:0], column_t'({$urandom, $urandom}));
    end
    add_vec(VecMax, VecMin, 32'sd1, -32'sd1, 0);
    add_vec(VecOne, VecOne, -VecOne, 32'sh1234_5678, 0);

    // random phases, each under its own matrix
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0:       add_matrix(ColumnReset[0], ColumnReset[1], ColumnReset[2], ColumnReset[3], p);
        2:       add_flat_matrix(CoefMax);
        5:       add_flat_matrix(CoefMin);
        8:       add_flat_matrix('0);
        default: add_matrix(rand_col(), rand_col(), rand_col(), rand_col(), p);
      endcase
      if ($urandom_range(2, 0) == 0) begin
        add_col(CfgIdxW'($urandom_range(2**CfgIdxW - 1, NumLanes)),
                column_t'({$urandom, $urandom}));
      end
      pct = (p % 4 == 3 || p == NumPhases - 1) ? 0 : $urandom_range(40, 10);
      if (p == NumPhases - 1) calm_after = vecs_total;
      for (int i = 0; i < PhaseVecs; i++) begin
        if (p % 3 == 1 && i == PhaseVecs / 2) add_drain();
        add_vec(rand_comp(), rand_comp(), rand_comp(), rand_comp(), pct);
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (feed_q.size() != 0 || in_valid || cfg_valid || transformed_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);

    $display("covered %0d vectors under %0d matrix settings, %0d of them clamped",
             vecs_sent, settings, clamped_seen);
    $display("%0d column writes (%0d to unused indexes), %0d drain pauses",
             col_writes, unused_writes, drain_pauses);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // hard limit on run time
  initial begin : limit_proc
    #(64'd5_000_000);
    $display("timeout with %0d results outstanding", transformed_q.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

/* mat4_vec4_transform.f */
+incdir+rtl/core
rtl/core/m4v4_pkg.sv
rtl/core/m4v4_lane.sv
rtl/core/m4v4_merge.sv
rtl/core/mat4_vec4_transform.sv
sim/mat4_vec4_transform_test.sv
